[rtl/core/nfa_char_stream_matcher_unit_macros.svh]
// Assertion macros for the character stream matcher.
// Used by the top level only; expects ports named clock and reset in scope.
`ifndef NFA_CHAR_STREAM_MATCHER_UNIT_MACROS_SVH
`define NFA_CHAR_STREAM_MATCHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCSM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ncsm_pkg.sv]
// Shared types and constants for the character stream matcher.
// No dependencies; used by every module of the block.
`default_nettype none

package ncsm_pkg;

   localparam int OP_W        = 2;
   localparam int NUM_W       = 6;
   localparam int SYM_W       = 8;
   localparam int STATE_FLD_W = 5;
   localparam int SLOT_FLD_W  = 3;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;

   localparam logic [OP_W-1:0] OP_RULE    = 2'd0;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
   localparam logic [OP_W-1:0] OP_CHAR    = 2'd2;

   localparam logic [SYM_W-1:0] SYM_MASK = 8'hFF;

   // One transition slot as held in the table.
   typedef struct packed {
      logic                   valid;
      logic [SYM_W-1:0]       symbol;
      logic [STATE_FLD_W-1:0] next;
   } slot_entry_type;

   // Outcome of comparing one slot against the current character.
   typedef struct packed {
      logic                   hit;
      logic [STATE_FLD_W-1:0] next;
   } match_type;

endpackage

`default_nettype wire

[rtl/core/ncsm_table.sv]
// Transition table memory: one write port and one registered read port.
// Depends on ncsm_pkg for the slot entry type.
`default_nettype none

module ncsm_table #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire ncsm_pkg::slot_entry_type wr_entry,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output ncsm_pkg::slot_entry_type     rd_entry
);

   ncsm_pkg::slot_entry_type slot_mem [DEPTH];
   ncsm_pkg::slot_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= slot_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

[rtl/core/ncsm_match.sv]
// Shared slot comparator: decides whether one table slot fires.
// Depends on ncsm_pkg for the slot and match types.
`default_nettype none

module ncsm_match #(
   parameter int N_W = 6
) (
   input  wire ncsm_pkg::slot_entry_type  entry,
   input  wire logic [ncsm_pkg::SYM_W-1:0] ch,
   input  wire logic                      src_active,
   input  wire logic [N_W-1:0]            n_states,
   output ncsm_pkg::match_type            result
);

   logic sym_eq;
   logic dest_ok;

   always_comb begin
      sym_eq  = (entry.symbol & ncsm_pkg::SYM_MASK) == (ch & ncsm_pkg::SYM_MASK);
      // Destinations outside the states in use are dropped.
      dest_ok = 32'(entry.next) < 32'(n_states);
      result.hit  = entry.valid && sym_eq && src_active && dest_ok;
      result.next = entry.next;
   end

endmodule

`default_nettype wire

[rtl/core/nfa_char_stream_matcher_unit.sv]
// A rule request is taken while idle and gives no response. A restart passes S_REPORT, which
// loads the response register once it is free. A character request walks every slot of the
// states in use through one shared comparator in S_SCAN, then passes S_DRAIN and S_REPORT.
// A new request is taken only back in S_IDLE; the single table read port paces the scan.
// Reset is synchronous: after it the table is cleared slot by slot in S_CLEAR, during
// which no request is taken, and state 0 is left as the only active state.
`default_nettype none

`include "nfa_char_stream_matcher_unit_macros.svh"

module nfa_char_stream_matcher_unit #(
   parameter int MAX_STATES    = 32,
   parameter int MAX_RELATIONS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [ncsm_pkg::NUM_W-1:0]         csr_wr_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rule_state[4:0], rule_slot[7:5], rule_symbol[15:8], rule_next[20:16],
   // rule_valid[21], ch[29:22], zero fill[31:30]
   input  wire logic [ncsm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[1:0]
   input  wire logic [ncsm_pkg::OP_W-1:0]          req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // alive[0], accepted[1], zero fill[7:2]
   output logic [ncsm_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   localparam int DEPTH  = MAX_STATES * MAX_RELATIONS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ST_W   = $clog2(MAX_STATES);
   localparam int SL_W   = (MAX_RELATIONS > 1) ? $clog2(MAX_RELATIONS) : 1;
   localparam int N_W    = $clog2(MAX_STATES + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_REPORT
   } state_type;

   state_type                          state_ff, state_in;
   logic [ADDR_W-1:0]                  clr_ff, clr_in;
   logic [ST_W-1:0]                    st_ff, st_in;
   logic [SL_W-1:0]                    sl_ff, sl_in;
   logic [ncsm_pkg::SYM_W-1:0]         ch_ff, ch_in;
   logic                               p_vld_ff, p_vld_in;
   logic                               p_act_ff, p_act_in;
   logic [MAX_STATES-1:0]              nxt_ff, nxt_in;
   logic [MAX_STATES-1:0]              active_ff, active_in;
   logic [ncsm_pkg::NUM_W-1:0]         num_ff, num_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic                               alive_ff, alive_in;
   logic                               acc_ff, acc_in;

   logic [ncsm_pkg::OP_W-1:0]          req_op;
   logic [ncsm_pkg::STATE_FLD_W-1:0]   req_rule_state;
   logic [ncsm_pkg::SLOT_FLD_W-1:0]    req_rule_slot;
   logic [ncsm_pkg::SYM_W-1:0]         req_rule_symbol;
   logic [ncsm_pkg::STATE_FLD_W-1:0]   req_rule_next;
   logic                               req_rule_valid;
   logic [ncsm_pkg::SYM_W-1:0]         req_ch;
   logic                               req_take;
   logic                               rule_in_range;
   logic                               restart_take;

   logic [N_W-1:0]                     n_use;
   logic [N_W-1:0]                     n_m1;
   logic [MAX_STATES-1:0]              use_mask;
   logic [MAX_STATES-1:0]              acc_sel;
   logic [MAX_STATES-1:0]              live;
   logic [MAX_STATES-1:0]              hit_vec;

   logic                               tbl_we;
   logic [ADDR_W-1:0]                  tbl_waddr;
   ncsm_pkg::slot_entry_type           tbl_wentry;
   logic [ADDR_W-1:0]                  tbl_raddr;
   ncsm_pkg::slot_entry_type           tbl_rentry;
   ncsm_pkg::match_type                mres;

   // Request unpacking.
   always_comb begin
      req_op          = req_tuser;
      req_rule_state  = req_tdata[4:0];
      req_rule_slot   = req_tdata[7:5];
      req_rule_symbol = req_tdata[15:8];
      req_rule_next   = req_tdata[20:16];
      req_rule_valid  = req_tdata[21];
      req_ch          = req_tdata[29:22];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rule_in_range = (32'(req_rule_state) < MAX_STATES) &&
                          (32'(req_rule_slot) < MAX_RELATIONS);
   assign restart_take = req_take && (req_op == ncsm_pkg::OP_RESTART);

   // Number of states in use, clamped to the range the table supports.
   always_comb begin
      if (num_ff == '0) begin
         n_use = N_W'(1);
      end else if (32'(num_ff) > MAX_STATES) begin
         n_use = N_W'(MAX_STATES);
      end else begin
         n_use = N_W'(num_ff);
      end
      n_m1 = n_use - N_W'(1);
      for (int k = 0; k < MAX_STATES; k++) begin
         use_mask[k] = 32'(k) < 32'(n_use);
         acc_sel[k]  = 32'(k) == 32'(n_m1);
      end
      live = active_ff & use_mask;
   end

   // Table write port: the clearing pass after reset, otherwise rule requests.
   always_comb begin
      tbl_we     = 1'b0;
      tbl_waddr  = clr_ff;
      tbl_wentry = '0;
      if (state_ff == S_CLEAR) begin
         tbl_we = 1'b1;
      end else if (req_take && (req_op == ncsm_pkg::OP_RULE) && rule_in_range) begin
         tbl_we            = 1'b1;
         tbl_waddr         = ADDR_W'(req_rule_state) * ADDR_W'(MAX_RELATIONS) +
                             ADDR_W'(req_rule_slot);
         tbl_wentry.valid  = req_rule_valid;
         tbl_wentry.symbol = req_rule_symbol & ncsm_pkg::SYM_MASK;
         tbl_wentry.next   = req_rule_next;
      end
      tbl_raddr = ADDR_W'(st_ff) * ADDR_W'(MAX_RELATIONS) + ADDR_W'(sl_ff);
   end

   ncsm_table #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_we),
      .wr_addr  (tbl_waddr),
      .wr_entry (tbl_wentry),
      .rd_addr  (tbl_raddr),
      .rd_entry (tbl_rentry)
   );

   ncsm_match #(
      .N_W (N_W)
   ) u_match (
      .entry      (tbl_rentry),
      .ch         (ch_ff),
      .src_active (p_act_ff),
      .n_states   (n_use),
      .result     (mres)
   );

   always_comb begin
      for (int k = 0; k < MAX_STATES; k++) begin
         hit_vec[k] = p_vld_ff && mres.hit && (32'(mres.next) == 32'(k));
      end
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      st_in      = st_ff;
      sl_in      = sl_ff;
      ch_in      = ch_ff;
      p_vld_in   = 1'b0;
      p_act_in   = p_act_ff;
      nxt_in     = nxt_ff | hit_vec;
      active_in  = active_ff;
      num_in     = num_ff;
      rsp_vld_in = rsp_vld_ff;
      alive_in   = alive_ff;
      acc_in     = acc_ff;

      if (csr_wr_en) begin
         num_in = csr_wr_data;
      end
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_take) begin
               case (req_op)
                  ncsm_pkg::OP_RESTART: begin
                     active_in = MAX_STATES'(1);
                     state_in  = S_REPORT;
                  end
                  ncsm_pkg::OP_CHAR: begin
                     ch_in    = req_ch;
                     nxt_in   = '0;
                     st_in    = '0;
                     sl_in    = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue one slot read per cycle; the compare happens in the cycle after the read.
            p_vld_in = 1'b1;
            p_act_in = active_ff[st_ff];
            if (sl_ff == SL_W'(MAX_RELATIONS - 1)) begin
               sl_in = '0;
               if (N_W'(st_ff) == n_m1) begin
                  state_in = S_DRAIN;
               end else begin
                  st_in = st_ff + ST_W'(1);
               end
            end else begin
               sl_in = sl_ff + SL_W'(1);
            end
         end
         S_DRAIN: begin
            active_in = nxt_in;
            state_in  = S_REPORT;
         end
         S_REPORT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               alive_in   = |live;
               acc_in     = |(live & acc_sel);
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         st_ff      <= '0;
         sl_ff      <= '0;
         ch_ff      <= '0;
         p_vld_ff   <= 1'b0;
         p_act_ff   <= 1'b0;
         nxt_ff     <= '0;
         active_ff  <= MAX_STATES'(1);
         num_ff     <= ncsm_pkg::NUM_W'(1);
         rsp_vld_ff <= 1'b0;
         alive_ff   <= 1'b0;
         acc_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         st_ff      <= st_in;
         sl_ff      <= sl_in;
         ch_ff      <= ch_in;
         p_vld_ff   <= p_vld_in;
         p_act_ff   <= p_act_in;
         nxt_ff     <= nxt_in;
         active_ff  <= active_in;
         num_ff     <= num_in;
         rsp_vld_ff <= rsp_vld_in;
         alive_ff   <= alive_in;
         acc_ff     <= acc_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(ncsm_pkg::RSP_DATA_W - 2)'(0), acc_ff, alive_ff};

   `NCSM_ASSERT_SAME(a_rsp_src, $rose(rsp_vld_ff), $past(state_ff == S_REPORT), "stray response")
   `NCSM_ASSERT_SAME(a_scan_in_range, state_ff == S_SCAN, 32'(st_ff) < 32'(n_use), "scan overrun")
   `NCSM_ASSERT_SAME(a_set_in_use, state_ff == S_REPORT, ~|(active_ff & ~use_mask), "stray state")
   `NCSM_ASSERT_NEXT(a_restart_set, restart_take, active_ff == MAX_STATES'(1), "restart missed")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for nfa_char_stream_matcher_unit: rule, restart and character requests
// are checked against an in-bench model of the automaton. Depends on ncsm_pkg and the block only.
`timescale 1ns / 100ps

module tb_top;

   localparam int MAX_STATES    = 32;
   localparam int MAX_RELATIONS = 8;
   localparam int TARGET_ITEMS  = 1500;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RULE_SETTLE   = 16;
   localparam int TAIL_CYCLES   = MAX_STATES * MAX_RELATIONS + 8;

   localparam int OP_W        = ncsm_pkg::OP_W;
   localparam int NUM_W       = ncsm_pkg::NUM_W;
   localparam int SYM_W       = ncsm_pkg::SYM_W;
   localparam int STATE_FLD_W = ncsm_pkg::STATE_FLD_W;
   localparam int SLOT_FLD_W  = ncsm_pkg::SLOT_FLD_W;
   localparam int REQ_DATA_W  = ncsm_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = ncsm_pkg::RSP_DATA_W;

   // The block ignores this opcode entirely.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]        op;
      logic [STATE_FLD_W-1:0] rule_state;
      logic [SLOT_FLD_W-1:0]  rule_slot;
      logic [SYM_W-1:0]       rule_symbol;
      logic [STATE_FLD_W-1:0] rule_next;
      logic                   rule_valid;
      logic [SYM_W-1:0]       ch;
   } request_type;

   typedef struct {
      logic alive;
      logic accepted;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [NUM_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Model of the automaton.
   ncsm_pkg::slot_entry_type rule_mem [0:MAX_STATES*MAX_RELATIONS-1];
   logic [31:0]              live_set;
   logic [NUM_W-1:0]         cfg_states;

   outcome_type expected_outcomes [$];

   bit idling = 1'b1;
   int mismatches;
   int items_sent;
   int responses_seen;
   int accepting_seen;
   int settings_used;
   int cycle_count;

   nfa_char_stream_matcher_unit #(
      .MAX_STATES   (MAX_STATES),
      .MAX_RELATIONS(MAX_RELATIONS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= idling ? ($urandom_range(0, 99) >= 33) : 1'b1;
   end

   always @(posedge clock) begin : check_response
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (rsp_tdata[1])
            accepting_seen++;
         if (expected_outcomes.size() == 0) begin
            $error("unexpected response: alive %0b accepted %0b", rsp_tdata[0], rsp_tdata[1]);
            mismatches++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_tdata[0] !== want.alive) begin
               $error("alive: expected %0b, actual %0b", want.alive, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[1] !== want.accepted) begin
               $error("accepted: expected %0b, actual %0b", want.accepted, rsp_tdata[1]);
               mismatches++;
            end
         end
      end
   end

   // A count of 0 behaves as 1 and anything above the table size as the table size.
   function automatic int effective_states(logic [NUM_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_STATES)
         return MAX_STATES;
      return int'(v);
   endfunction

   function automatic logic [31:0] span_mask(int n);
      logic [63:0] m;
      m = (64'd1 << n) - 64'd1;
      return m[31:0];
   endfunction

   function automatic bit step_automaton(request_type r, output outcome_type o);
      int                       n;
      logic [31:0]              cur;
      logic [31:0]              nxt;
      ncsm_pkg::slot_entry_type e;
      n = effective_states(cfg_states);
      o = '{alive: 1'b0, accepted: 1'b0};
      case (r.op)
         ncsm_pkg::OP_RULE: begin
            rule_mem[r.rule_state * MAX_RELATIONS + r.rule_slot] =
               '{valid: r.rule_valid, symbol: r.rule_symbol, next: r.rule_next};
            return 1'b0;
         end
         ncsm_pkg::OP_RESTART: begin
            live_set = 32'd1;
         end
         ncsm_pkg::OP_CHAR: begin
            cur = live_set & span_mask(n);
            nxt = '0;
            for (int i = 0; i < n; i++) begin
               if (cur[i]) begin
                  for (int j = 0; j < MAX_RELATIONS; j++) begin
                     e = rule_mem[i * MAX_RELATIONS + j];
                     if (e.valid && e.symbol == r.ch && int'(e.next) < n)
                        nxt[e.next] = 1'b1;
                  end
               end
            end
            live_set = nxt;
         end
         default: return 1'b0;
      endcase
      cur = live_set & span_mask(n);
      o.alive    = (cur != 0);
      o.accepted = cur[n-1];
      return 1'b1;
   endfunction

   // Fields that the opcode does not use are filled with random values.
   function automatic request_type bare_req(logic [OP_W-1:0] op);
      request_type r;
      r.op          = op;
      r.rule_state  = STATE_FLD_W'($urandom);
      r.rule_slot   = SLOT_FLD_W'($urandom);
      r.rule_symbol = SYM_W'($urandom);
      r.rule_next   = STATE_FLD_W'($urandom);
      r.rule_valid  = 1'($urandom);
      r.ch          = SYM_W'($urandom);
      return r;
   endfunction

   function automatic request_type rule_req(int st, int sl, logic [SYM_W-1:0] sym, int nx,
                                            logic vld);
      request_type r;
      r             = bare_req(ncsm_pkg::OP_RULE);
      r.rule_state  = STATE_FLD_W'(st);
      r.rule_slot   = SLOT_FLD_W'(sl);
      r.rule_symbol = sym;
      r.rule_next   = STATE_FLD_W'(nx);
      r.rule_valid  = vld;
      return r;
   endfunction

   function automatic request_type char_req(logic [SYM_W-1:0] c);
      request_type r;
      r    = bare_req(ncsm_pkg::OP_CHAR);
      r.ch = c;
      return r;
   endfunction

   task automatic send_request(request_type r);
      outcome_type o;
      if (idling && $urandom_range(0, 99) < 33) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_tdata  = {2'b00, r.ch, r.rule_valid, r.rule_next, r.rule_symbol, r.rule_slot,
                    r.rule_state};
      req_tuser  = r.op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (r.op != OP_UNUSED)
         items_sent++;
      if (step_automaton(r, o))
         expected_outcomes.push_back(o);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Drains all responses and idles before the state count is written.
   task automatic write_state_count(logic [NUM_W-1:0] v);
      drain_responses();
      repeat (RULE_SETTLE) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      cfg_states  = v;
      settings_used++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(char_req(8'h00));
      send_request(char_req(8'h41));
      send_request(bare_req(OP_UNUSED));
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(rule_req(0, 0, 8'h61, 0, 1'b1));
      send_request(char_req(8'h61));
   endtask

   task automatic test_range_cases();
      write_state_count(6'd63);
      send_request(rule_req(0, 7, 8'hFF, 31, 1'b1));
      send_request(rule_req(31, 0, 8'h00, 0, 1'b1));
      send_request(rule_req(31, 7, 8'hFF, 31, 1'b1));
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(char_req(8'hFF));
      send_request(char_req(8'hFF));
      send_request(char_req(8'h00));
      // With two states the jump to state 31 is dropped.
      write_state_count(6'd2);
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(char_req(8'hFF));
      send_request(rule_req(1, 3, 8'h00, 1, 1'b1));
      send_request(rule_req(0, 1, 8'h42, 1, 1'b1));
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(char_req(8'h42));
      send_request(char_req(8'h00));
      send_request(rule_req(0, 1, 8'h42, 1, 1'b0));
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(char_req(8'h42));
      write_state_count(6'd0);
      send_request(bare_req(ncsm_pkg::OP_RESTART));
      send_request(char_req(8'h61));
   endtask

   task automatic test_random_automata();
      int               phase;
      int               n;
      int               pick;
      int               alen;
      int               strings;
      int               len;
      logic [SYM_W-1:0] alpha [4];
      logic [NUM_W-1:0] setting;
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       setting = 6'd32;
            1:       setting = NUM_W'($urandom_range(33, 63));
            2:       setting = NUM_W'($urandom_range(0, 1));
            default: setting = NUM_W'($urandom_range(2, 8));
         endcase
         write_state_count(setting);
         n = effective_states(setting);
         idling = (phase != 2);

         alen = $urandom_range(2, 4);
         foreach (alpha[k])
            alpha[k] = SYM_W'($urandom);

         // A chain through every state reaches the accepting one; extra slots branch.
         for (int i = 0; i < n; i++) begin
            send_request(rule_req(i, $urandom_range(0, MAX_RELATIONS - 1),
                                  alpha[$urandom_range(0, alen - 1)],
                                  (i < n - 1) ? i + 1 : $urandom_range(0, n - 1), 1'b1));
            repeat ($urandom_range(0, (n > 16) ? 1 : 2)) begin
               send_request(rule_req(i, $urandom_range(0, MAX_RELATIONS - 1),
                                     alpha[$urandom_range(0, alen - 1)],
                                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                                 : $urandom_range(0, n - 1),
                                     $urandom_range(0, 7) != 0));
            end
         end

         strings = (n > 16) ? 2 : $urandom_range(5, 9);
         repeat (strings) begin
            if ($urandom_range(0, 9) != 0)
               send_request(bare_req(ncsm_pkg::OP_RESTART));
            len = $urandom_range(1, (n > 16) ? 6 : 10);
            repeat (len) begin
               if ($urandom_range(0, 19) == 0)
                  send_request(($urandom_range(0, 1) == 0) ? bare_req(OP_UNUSED)
                                                           : bare_req(ncsm_pkg::OP_RULE));
               if ($urandom_range(0, 99) < 88)
                  send_request(char_req(alpha[$urandom_range(0, alen - 1)]));
               else
                  send_request(char_req(SYM_W'($urandom)));
            end
         end
         phase++;
      end
      idling = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < MAX_STATES * MAX_RELATIONS; i++)
         rule_mem[i] = '0;
      live_set   = 32'd1;
      cfg_states = NUM_W'(1);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_range_cases();
      test_random_automata();

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests under %0d state-count settings, including 0, 1, 32 and above.",
               items_sent, settings_used);
      $display("Checked %0d responses, %0d of them with the accepting state active.",
               responses_seen, accepting_seen);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
